[rtl/core/pls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the label store
// Register indexes, item kinds, sequencer states and storage widths.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned VerticesDefault = 16;
  localparam int unsigned DepthDefault    = 64;

  localparam int unsigned CostW   = 32;
  localparam int unsigned EnergyW = 16;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned SlackW  = 8;
  localparam int unsigned PosW    = 7;
  localparam int unsigned VertW   = 4;

  // one stored entry: label plus prefix bounds
  localparam int unsigned EntryW = CostW + 2 * EnergyW + TimeW + EnergyW + TimeW;

  localparam logic [0:0] RegEnergySlack = 1'b0;
  localparam logic [0:0] RegTimeSlack   = 1'b1;

  localparam logic KindCheck  = 1'b0;
  localparam logic KindInsert = 1'b1;

  typedef struct packed {
    logic [CostW-1:0]   cost;
    logic [EnergyW-1:0] raw_energy;
    logic [EnergyW-1:0] eff_energy;
    logic [TimeW-1:0]   eff_time;
    logic [EnergyW-1:0] emax;
    logic [TimeW-1:0]   tmin;
  } entry_t;

  typedef enum logic [3:0] {
    StIdle,
    StSrchRd,
    StSrchWt,
    StSrchCmp,
    StWalkRd,
    StWalkWt,
    StWalkCmp,
    StShRd,
    StShWt,
    StShWr,
    StPut,
    StFixRd,
    StFixWt,
    StFixWr,
    StDone
  } state_e;

endpackage
`default_nettype wire

[rtl/core/pls_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram: generic single-port RAM
// One write and one read per cycle at one address, registered read data (old data on a write).
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[rtl/core/pls_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_cfg: APB register file
// Holds the energy and time tolerances.
// ----------------------------------------------------------------------------
module pls_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [pls_pkg::SlackW-1:0] energy_slack_o,
  output logic      [pls_pkg::SlackW-1:0] time_slack_o
);

  logic [pls_pkg::SlackW-1:0] es_q, ts_q;
  logic                       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q <= pls_pkg::SlackW'(1);
      ts_q <= pls_pkg::SlackW'(1);
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == pls_pkg::RegEnergySlack) es_q <= pwdata[pls_pkg::SlackW-1:0];
      else                                     ts_q <= pwdata[pls_pkg::SlackW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == pls_pkg::RegEnergySlack) prdata[pls_pkg::SlackW-1:0] = es_q;
      else                                     prdata[pls_pkg::SlackW-1:0] = ts_q;
    end
  end

  assign energy_slack_o = es_q;
  assign time_slack_o   = ts_q;

endmodule
`default_nettype wire

[rtl/core/pls_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_seq: list sequencer
// Binary search, backward dominance walk, shift and prefix repair, all
// through one RAM port and one shared compare unit.
// ----------------------------------------------------------------------------
module pls_seq #(
  parameter int unsigned Vertices = pls_pkg::VerticesDefault,
  parameter int unsigned Depth    = pls_pkg::DepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        kind_i,
  input  wire logic [pls_pkg::VertW-1:0]   vertex_i,
  input  wire logic [pls_pkg::CostW-1:0]   label_cost_i,
  input  wire logic [pls_pkg::EnergyW-1:0] raw_energy_i,
  input  wire logic [pls_pkg::EnergyW-1:0] eff_energy_i,
  input  wire logic [pls_pkg::TimeW-1:0]   eff_time_i,
  input  wire logic [pls_pkg::SlackW-1:0]  energy_slack_i,
  input  wire logic [pls_pkg::SlackW-1:0]  time_slack_i,
  output logic                             done_o,
  output logic                             dominated_o,
  output logic [pls_pkg::PosW-1:0]         position_o,
  output logic                             full_res_o
);

  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned LenW  = $clog2(Depth + 1);
  localparam int unsigned VIdxW = (Vertices > 1) ? $clog2(Vertices) : 1;
  localparam int unsigned AddrW = $clog2(Vertices * Depth);

  pls_pkg::state_e st_q, st_d;

  logic [LenW-1:0] len_q [Vertices];
  logic            kind_q;
  logic [VIdxW-1:0] v_q;
  logic [pls_pkg::CostW-1:0]   c_q;
  logic [pls_pkg::EnergyW-1:0] r_q, e_q;
  logic [pls_pkg::TimeW-1:0]   t_q;
  logic [LenW-1:0] first_q, first_d, cnt_q, cnt_d, i_q, i_d, len_cur_q, len_cur_d;
  logic            dom_q, dom_d, full_q, full_d;
  logic [pls_pkg::EnergyW-1:0] pmax_q, pmax_d;
  logic [pls_pkg::TimeW-1:0]   pmin_q, pmin_d;

  logic                 we;
  logic [LenW-1:0]      idx;
  logic [AddrW-1:0]     addr;
  pls_pkg::entry_t      wentry, rentry;
  logic [LenW-1:0]      step;
  logic                 cand_first;
  logic [pls_pkg::EnergyW:0] e_sum, p_sum;
  logic [pls_pkg::TimeW:0]   t_lim;
  logic                 vert_ok;
  logic                 len_we;
  logic [pls_pkg::EnergyW-1:0] fmax;
  logic [pls_pkg::TimeW-1:0]   fmin;

  pls_ram #(.Width(pls_pkg::EntryW), .Depth(Vertices * Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wentry),
    .rdata_o (rentry)
  );

  // flat address: vertex * Depth + index
  assign addr = AddrW'(v_q) * AddrW'(Depth) + AddrW'(idx[IdxW-1:0]);
  assign vert_ok = 32'(vertex_i) < Vertices;
  assign step    = cnt_q >> 1;

  // shared compare unit
  always_comb begin
    if (c_q != rentry.cost)               cand_first = c_q < rentry.cost;
    else if (r_q != rentry.raw_energy)    cand_first = e_q > rentry.eff_energy;
    else                                  cand_first = t_q < rentry.eff_time;
    e_sum = {1'b0, rentry.eff_energy} + (pls_pkg::EnergyW+1)'(energy_slack_i);
    p_sum = {1'b0, rentry.emax} + (pls_pkg::EnergyW+1)'(energy_slack_i);
    t_lim = {1'b0, t_q} + (pls_pkg::TimeW+1)'(time_slack_i);
    fmax  = (i_q != '0 && pmax_q > rentry.eff_energy) ? pmax_q : rentry.eff_energy;
    fmin  = (i_q != '0 && pmin_q < rentry.eff_time) ? pmin_q : rentry.eff_time;
  end

  always_comb begin
    st_d = st_q;
    first_d = first_q; cnt_d = cnt_q; i_d = i_q; len_cur_d = len_cur_q;
    dom_d = dom_q; full_d = full_q; pmax_d = pmax_q; pmin_d = pmin_q;
    we = 1'b0; idx = i_q; wentry = rentry; len_we = 1'b0;
    case (st_q)
      pls_pkg::StIdle: begin
        if (start_i) begin
          first_d = '0; dom_d = 1'b0; full_d = 1'b0;
          if (vert_ok) begin
            len_cur_d = len_q[vertex_i[VIdxW-1:0]];
            cnt_d = len_q[vertex_i[VIdxW-1:0]];
            st_d = pls_pkg::StSrchRd;
          end else begin
            cnt_d = '0; len_cur_d = '0;
            st_d = pls_pkg::StDone;
          end
        end
      end
      pls_pkg::StSrchRd: begin
        if (cnt_q == '0) begin
          i_d = first_q;
          st_d = pls_pkg::StWalkRd;
        end else begin
          idx = first_q + step;
          st_d = pls_pkg::StSrchWt;
        end
      end
      pls_pkg::StSrchWt: begin
        idx = first_q + step;
        st_d = pls_pkg::StSrchCmp;
      end
      pls_pkg::StSrchCmp: begin
        idx = first_q + step;
        if (!cand_first) begin
          first_d = first_q + step + LenW'(1);
          cnt_d = cnt_q - step - LenW'(1);
        end else begin
          cnt_d = step;
        end
        st_d = pls_pkg::StSrchRd;
      end
      pls_pkg::StWalkRd: begin
        idx = i_q - LenW'(1);
        if (i_q == '0) st_d = pls_pkg::StShRd;
        else           st_d = pls_pkg::StWalkWt;
        if (i_q == '0) i_d = len_cur_q;
      end
      pls_pkg::StWalkWt: begin
        idx = i_q - LenW'(1);
        st_d = pls_pkg::StWalkCmp;
      end
      pls_pkg::StWalkCmp: begin
        idx = i_q - LenW'(1);
        if (p_sum < {1'b0, e_q} || {1'b0, rentry.tmin} > t_lim) begin
          i_d = len_cur_q; st_d = pls_pkg::StShRd;
        end else if (e_sum >= {1'b0, e_q} && {1'b0, rentry.eff_time} <= t_lim) begin
          dom_d = 1'b1; i_d = len_cur_q; st_d = pls_pkg::StShRd;
        end else begin
          i_d = i_q - LenW'(1); st_d = pls_pkg::StWalkRd;
        end
      end
      pls_pkg::StShRd: begin
        // shift entries up from the list end down to the insert slot
        idx = i_q - LenW'(1);
        if (kind_q != pls_pkg::KindInsert) begin
          st_d = pls_pkg::StDone;
        end else if (32'(len_cur_q) >= Depth) begin
          full_d = 1'b1; st_d = pls_pkg::StDone;
        end else if (i_q == first_q) begin
          st_d = pls_pkg::StPut;
        end else begin
          st_d = pls_pkg::StShWt;
        end
      end
      pls_pkg::StShWt: begin
        idx = i_q - LenW'(1);
        st_d = pls_pkg::StShWr;
      end
      pls_pkg::StShWr: begin
        we = 1'b1; idx = i_q; wentry = rentry;
        i_d = i_q - LenW'(1);
        st_d = pls_pkg::StShRd;
      end
      pls_pkg::StPut: begin
        we = 1'b1; idx = first_q;
        wentry = '{cost: c_q, raw_energy: r_q, eff_energy: e_q, eff_time: t_q,
                   emax: e_q, tmin: t_q};
        len_we = 1'b1; len_cur_d = len_cur_q + LenW'(1);
        i_d = first_q;
        st_d = pls_pkg::StFixRd;
        if (first_q != '0) i_d = first_q - LenW'(1);
      end
      pls_pkg::StFixRd: begin
        // walk from just before the slot to the end carrying running bounds
        if (i_q == len_cur_q) st_d = pls_pkg::StDone;
        else                  st_d = pls_pkg::StFixWt;
      end
      pls_pkg::StFixWt: st_d = pls_pkg::StFixWr;
      pls_pkg::StFixWr: begin
        if (i_q < first_q) begin
          pmax_d = rentry.emax; pmin_d = rentry.tmin;
        end else begin
          we = 1'b1;
          wentry = rentry; wentry.emax = fmax; wentry.tmin = fmin;
          pmax_d = fmax; pmin_d = fmin;
        end
        i_d = i_q + LenW'(1);
        st_d = pls_pkg::StFixRd;
      end
      pls_pkg::StDone: st_d = pls_pkg::StIdle;
      default: st_d = pls_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pls_pkg::StIdle;
      for (int k = 0; k < Vertices; k++) len_q[k] <= '0;
    end else begin
      st_q <= st_d;
      if (len_we) len_q[v_q] <= len_cur_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == pls_pkg::StIdle && start_i) begin
      kind_q <= kind_i; v_q <= vertex_i[VIdxW-1:0]; c_q <= label_cost_i;
      r_q <= raw_energy_i; e_q <= eff_energy_i; t_q <= eff_time_i;
    end
    first_q <= first_d; cnt_q <= cnt_d; i_q <= i_d; len_cur_q <= len_cur_d;
    dom_q <= dom_d; full_q <= full_d; pmax_q <= pmax_d; pmin_q <= pmin_d;
  end

  assign busy_o      = st_q != pls_pkg::StIdle;
  assign done_o      = st_q == pls_pkg::StDone;
  assign dominated_o = dom_q;
  assign position_o  = pls_pkg::PosW'(first_q);
  assign full_res_o  = full_q;

endmodule
`default_nettype wire

[rtl/core/pareto_label_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pareto_label_store: per-vertex sorted label lists with dominance check
//
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+-----------------
//  command  | start_i, busy_o, kind_i .. eff_time_i     | start & !busy
//  result   | done_o, dominated_o, position_o, full_res_o | one-cycle strobe
//  config   | psel, penable, pwrite, paddr, pwdata ...  | APB, pready=1
//
// Each search probe, walk step, shifted entry and repaired entry passes through
// a read, a wait and a compare or write state, all bound by the single RAM port
// shared by every phase.
// Reset clears the list lengths; stored entries need no clearing.
// The receiver cannot stall; busy stays high until the done strobe.
// ----------------------------------------------------------------------------
module pareto_label_store #(
  parameter int unsigned Vertices = pls_pkg::VerticesDefault,
  parameter int unsigned Depth    = pls_pkg::DepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        kind_i,
  input  wire logic [pls_pkg::VertW-1:0]   vertex_i,
  input  wire logic [pls_pkg::CostW-1:0]   label_cost_i,
  input  wire logic [pls_pkg::EnergyW-1:0] raw_energy_i,
  input  wire logic [pls_pkg::EnergyW-1:0] eff_energy_i,
  input  wire logic [pls_pkg::TimeW-1:0]   eff_time_i,
  output logic                             done_o,
  output logic                             dominated_o,
  output logic [pls_pkg::PosW-1:0]         position_o,
  output logic                             full_res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [pls_pkg::SlackW-1:0] es, ts;

  pls_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .energy_slack_o (es),
    .time_slack_o   (ts)
  );

  pls_seq #(.Vertices(Vertices), .Depth(Depth)) u_seq (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .vertex_i, .label_cost_i,
    .raw_energy_i, .eff_energy_i, .eff_time_i,
    .energy_slack_i (es),
    .time_slack_i   (ts),
    .done_o, .dominated_o, .position_o, .full_res_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_full_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && full_res_o |-> 32'(position_o) <= Depth) else $error("bad full");

endmodule
`default_nettype wire

[tb/sv/pareto_label_store_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_label_store_tb: self-checking bench for the label store
// Drives check and insert words through the start/busy port, sets the slack
// registers over the APB port between phases, and compares every done strobe
// against a behavioral copy of the sorted per-vertex lists.
// ----------------------------------------------------------------------------

class label_scoreboard;
  localparam int NV = 16;
  localparam int ND = 64;

  typedef struct {
    logic       dominated;
    logic [6:0] position;
    logic       full;
  } outcome_t;

  // shadow lists
  logic [31:0] cost_q   [NV][ND];
  logic [15:0] raw_q    [NV][ND];
  logic [15:0] energy_q [NV][ND];
  logic [23:0] time_q   [NV][ND];
  logic [15:0] emax_q   [NV][ND];
  logic [23:0] tmin_q   [NV][ND];
  int          len_q    [NV];
  int unsigned e_slack;
  int unsigned t_slack;
  outcome_t    pending[$];
  int          mismatches;

  function new();
    foreach (len_q[i]) len_q[i] = 0;
    e_slack    = 1;
    t_slack    = 1;
    mismatches = 0;
  endfunction

  function void set_slack(logic is_time, logic [7:0] value);
    if (is_time) t_slack = value;
    else e_slack = value;
  endfunction

  function bit goes_first(int v, int k, logic [31:0] c, logic [15:0] r,
                          logic [15:0] e, logic [23:0] t);
    if (c != cost_q[v][k]) return c < cost_q[v][k];
    if (r != raw_q[v][k]) return e > energy_q[v][k];
    return t < time_q[v][k];
  endfunction

  // accepted word: compute its outcome and update the shadow lists
  function void note_item(logic kind, logic [3:0] v, logic [31:0] c, logic [15:0] r,
                          logic [15:0] e, logic [23:0] t);
    outcome_t    o;
    int          first, count, step, len, i;
    int unsigned tlim;
    logic [15:0] mx;
    logic [23:0] mn;
    o.dominated = 1'b0;
    o.full      = 1'b0;
    len   = len_q[v];
    first = 0;
    count = len;
    while (count > 0) begin
      step = count / 2;
      if (!goes_first(v, first + step, c, r, e, t)) begin
        first += step + 1;
        count -= step + 1;
      end else begin
        count = step;
      end
    end
    o.position = first[6:0];
    tlim = int'(t) + t_slack;
    for (i = first - 1; i >= 0; i--) begin
      if (int'(emax_q[v][i]) + e_slack < int'(e) || int'(tmin_q[v][i]) > tlim) break;
      if (int'(energy_q[v][i]) + e_slack >= int'(e) && int'(time_q[v][i]) <= tlim) begin
        o.dominated = 1'b1;
        break;
      end
    end
    if (kind == pls_pkg::KindInsert) begin
      if (len >= ND) begin
        o.full = 1'b1;
      end else begin
        for (i = len; i > first; i--) begin
          cost_q[v][i]   = cost_q[v][i-1];
          raw_q[v][i]    = raw_q[v][i-1];
          energy_q[v][i] = energy_q[v][i-1];
          time_q[v][i]   = time_q[v][i-1];
        end
        cost_q[v][first]   = c;
        raw_q[v][first]    = r;
        energy_q[v][first] = e;
        time_q[v][first]   = t;
        len_q[v] = len + 1;
        for (i = first; i <= len; i++) begin
          mx = energy_q[v][i];
          mn = time_q[v][i];
          if (i > 0) begin
            if (emax_q[v][i-1] > mx) mx = emax_q[v][i-1];
            if (tmin_q[v][i-1] < mn) mn = tmin_q[v][i-1];
          end
          emax_q[v][i] = mx;
          tmin_q[v][i] = mn;
        end
      end
    end
    pending.push_back(o);
  endfunction

  function void check_result(logic dom, logic [6:0] pos, logic full);
    outcome_t o;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result dom=%0b pos=%0d full=%0b",
                                     dom, pos, full);
      return;
    end
    o = pending.pop_front();
    if (dom !== o.dominated || pos !== o.position || full !== o.full) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp dom=%0b pos=%0d full=%0b, got dom=%0b pos=%0d full=%0b",
                 o.dominated, o.position, o.full, dom, pos, full);
    end
  endfunction
endclass

module pareto_label_store_tb;
  import pls_pkg::*;

  localparam longint CycleLimit = 3000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               kind;
  logic [VertW-1:0]   vertex;
  logic [CostW-1:0]   label_cost;
  logic [EnergyW-1:0] raw_energy;
  logic [EnergyW-1:0] eff_energy;
  logic [TimeW-1:0]   eff_time;
  logic               done;
  logic               dominated;
  logic [PosW-1:0]    position;
  logic               full_res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  label_scoreboard lists;
  longint          cycles;
  int              idle_pct;

  pareto_label_store u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .kind_i       (kind),
    .vertex_i     (vertex),
    .label_cost_i (label_cost),
    .raw_energy_i (raw_energy),
    .eff_energy_i (eff_energy),
    .eff_time_i   (eff_time),
    .done_o       (done),
    .dominated_o  (dominated),
    .position_o   (position),
    .full_res_o   (full_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial lists = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && done) lists.check_result(dominated, position, full_res);
  end

  task automatic write_slack(logic is_time, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {is_time ? RegTimeSlack : RegEnergySlack, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lists.set_slack(is_time, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // send one word; start stays high into the next word unless a gap follows
  task automatic send_word(logic k, logic [3:0] v, logic [31:0] c, logic [15:0] r,
                           logic [15:0] e, logic [23:0] t);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(6, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    kind       <= k;
    vertex     <= v;
    label_cost <= c;
    raw_energy <= r;
    eff_energy <= e;
    eff_time   <= t;
    do @(posedge clk); while (busy);
    lists.note_item(k, v, c, r, e, t);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (lists.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_word();
    logic        k;
    logic [3:0]  v;
    logic [31:0] c;
    logic [15:0] r, e;
    logic [23:0] t;
    k = ($urandom_range(99) < 65) ? KindInsert : KindCheck;
    v = ($urandom_range(1)) ? 4'($urandom_range(3)) : 4'($urandom);
    c = ($urandom_range(99) < 75) ? 32'($urandom_range(40)) : $urandom;
    r = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
    e = ($urandom_range(1)) ? 16'($urandom_range(300)) : 16'($urandom);
    t = ($urandom_range(1)) ? 24'($urandom_range(300)) : 24'($urandom);
    send_word(k, v, c, r, e, t);
  endtask

  initial begin
    cycles     = 0;
    idle_pct   = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    kind       = KindCheck;
    vertex     = '0;
    label_cost = '0;
    raw_energy = '0;
    eff_energy = '0;
    eff_time   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset slack, then tight slack
    send_word(KindCheck,  4'd3, 32'd100, 16'd5, 16'd50, 24'd100);  // empty list
    send_word(KindInsert, 4'd3, 32'd100, 16'd5, 16'd50, 24'd100);
    send_word(KindCheck,  4'd3, 32'd100, 16'd6, 16'd60, 24'd100);  // cost tie, raw differs
    send_word(KindCheck,  4'd3, 32'd100, 16'd5, 16'd50, 24'd99);   // full tie, time decides
    send_word(KindInsert, 4'd3, 32'd200, 16'd1, 16'd40, 24'd200);  // dominated insert
    send_word(KindInsert, 4'd3, 32'd0,   16'd0, 16'd0,  24'd0);
    send_word(KindInsert, 4'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    send_word(KindCheck,  4'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 24'hFF_FFFF);
    drain();
    write_slack(1'b0, 8'd0);
    write_slack(1'b1, 8'd0);
    send_word(KindCheck,  4'd3, 32'd300, 16'd5, 16'd51, 24'd100);  // energy bound exits walk
    send_word(KindCheck,  4'd3, 32'd300, 16'd5, 16'd50, 24'd100);
    send_word(KindCheck,  4'd3, 32'd300, 16'd5, 16'd40, 24'd99);
    send_word(KindInsert, 4'd15, 32'd7, 16'hFFFF, 16'hFFFF, 24'd0);
    send_word(KindInsert, 4'd15, 32'd7, 16'h0, 16'h0, 24'hFF_FFFF);
    send_word(KindInsert, 4'd15, 32'd7, 16'hFFFF, 16'h1, 24'd5);
    send_word(KindCheck,  4'd15, 32'd8, 16'd3, 16'd1, 24'd5);
    // fill one list to refuse an insert
    for (int i = 0; i < 64; i++)
      send_word(KindInsert, 4'd9, 32'($urandom_range(20)), 16'($urandom_range(2)),
                16'($urandom), 24'($urandom));
    send_word(KindInsert, 4'd9, 32'd5, 16'd1, 16'd1, 24'd1);
    send_word(KindCheck,  4'd9, 32'd5, 16'd1, 16'd1, 24'd1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 10;
          write_slack(1'b0, 8'd255);
          write_slack(1'b1, 8'd255);
        end
        1: begin
          idle_pct = 47;
          write_slack(1'b0, 8'($urandom_range(20)));
          write_slack(1'b1, 8'($urandom_range(20)));
        end
        default: begin
          idle_pct = 0;
          write_slack(1'b0, 8'd1);
          write_slack(1'b1, 8'($urandom_range(255)));
        end
      endcase
      for (int n = 0; n < 390; n++) random_word();
      drain();
    end

    if (lists.mismatches == 0 && lists.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
